// File: sv/can_table_request_responder_macros.svh
// assertion helpers for the can table request responder
`ifndef CAN_TABLE_REQUEST_RESPONDER_MACROS_SVH
`define CAN_TABLE_REQUEST_RESPONDER_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold on every rising clock edge outside reset
`define CANTRR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("cantrr assertion failed");
// expression must never be true outside reset
`define CANTRR_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("cantrr forbidden condition seen");
`else
`define CANTRR_ASSERT(lbl, clk, rstn, prop)
`define CANTRR_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// File: sv/cantrr_pkg.sv
package cantrr_pkg;

  // message types carried in the extended id
  localparam logic [2:0] TypeCmd = 3'd0;
  localparam logic [2:0] TypeReq = 3'd1;
  localparam logic [2:0] TypeRsp = 3'd2;

  // status table served on requests
  localparam logic [4:0] StatusTable    = 5'd7;
  localparam logic [9:0] StatusOffFault = 10'd2;
  localparam logic [9:0] StatusOffSpeed = 10'd10;

  // writable table window
  localparam logic [4:0]  StoreTable    = 5'd9;
  localparam logic [9:0]  StoreOffBase  = 10'd256;
  localparam logic [10:0] StoreOffLimit = 11'd512;

  localparam logic [3:0] MaxLen = 4'd8;

  // configuration register indexes and reset values
  localparam logic RegNodeId = 1'b0;
  localparam logic RegBaseId = 1'b1;
  localparam logic [3:0]  NodeIdReset = 4'd5;
  localparam logic [10:0] BaseIdReset = 11'd1512;

  // one received frame plus the live status words
  typedef struct packed {
    logic               is_extended;
    logic [28:0]        frame_id;
    logic [3:0]         frame_len;
    logic [63:0]        frame_payload;
    logic [15:0]        fault_word;
    logic [15:0]        vehicle_speed;
    logic signed [15:0] accel_x_hundredths;
    logic signed [15:0] accel_y_hundredths;
    logic signed [15:0] accel_z_hundredths;
  } item_t;

  // result of one frame
  typedef struct packed {
    logic        accepted;
    logic        send_response;
    logic [28:0] response_id;
    logic [3:0]  response_len;
    logic [63:0] response_payload;
    logic [3:0]  bytes_stored;
  } result_t;

  // state update requested by one frame
  typedef struct packed {
    logic        grp_we;
    logic [1:0]  grp_idx;
    logic [63:0] data;
    logic [7:0]  lane_en;
    logic [8:0]  tbl_base;
  } store_wr_t;

endpackage

// File: sv/cantrr_cfg.sv
module cantrr_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [3:0]  node_id_o,
  output logic [10:0] base_id_o
);

  logic [3:0]  node_id_q, node_id_d;
  logic [10:0] base_id_q, base_id_d;
  logic        wr_en;
  logic        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[2];

  // register write decode
  always_comb begin
    node_id_d = node_id_q;
    base_id_d = base_id_q;
    if (wr_en) begin
      case (reg_idx)
        cantrr_pkg::RegNodeId: node_id_d = pwdata[3:0];
        cantrr_pkg::RegBaseId: base_id_d = pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q <= cantrr_pkg::NodeIdReset;
      base_id_q <= cantrr_pkg::BaseIdReset;
    end else begin
      node_id_q <= node_id_d;
      base_id_q <= base_id_d;
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      cantrr_pkg::RegNodeId: prdata = {28'd0, node_id_q};
      cantrr_pkg::RegBaseId: prdata = {21'd0, base_id_q};
      default:               prdata = 32'd0;
    endcase
  end

  assign node_id_o = node_id_q;
  assign base_id_o = base_id_q;

endmodule

// File: sv/cantrr_decode.sv
module cantrr_decode #(
  parameter int StoreBytes = 256
) (
  input  cantrr_pkg::item_t     item_i,
  input  logic [3:0]            node_id_i,
  input  logic [10:0]           base_id_i,
  output cantrr_pkg::result_t   result_o,
  output cantrr_pkg::store_wr_t wr_o
);

  logic [4:0]  table_no;
  logic [3:0]  dest;
  logic [3:0]  src;
  logic [2:0]  msg_kind;
  logic [9:0]  offset;
  logic [7:0]  b0, b1, b2;
  logic [9:0]  roff;
  logic [3:0]  req_len;
  logic [3:0]  wr_len;
  logic [11:0] base_top;
  logic        std_hit;
  logic [28:0] std_diff;
  logic        for_me;
  logic        is_store;
  logic [8:0]  tbl_base;
  logic [7:0]  lane_en;
  logic [10:0] lane_idx;

  // extended id fields
  assign table_no = {item_i.frame_id[2], item_i.frame_id[6:3]};
  assign dest     = item_i.frame_id[10:7];
  assign src      = item_i.frame_id[14:11];
  assign msg_kind = item_i.frame_id[17:15];
  assign offset   = item_i.frame_id[27:18];

  // request fields from the payload
  assign b0      = item_i.frame_payload[63:56];
  assign b1      = item_i.frame_payload[55:48];
  assign b2      = item_i.frame_payload[47:40];
  assign roff    = {b1[6:0], b2[7:5]};
  assign req_len = (b2[3:0] > cantrr_pkg::MaxLen) ? cantrr_pkg::MaxLen : b2[3:0];
  assign wr_len  = (item_i.frame_len > cantrr_pkg::MaxLen) ? cantrr_pkg::MaxLen
                                                           : item_i.frame_len;

  // standard id window, compared without wrap
  assign base_top = {1'b0, base_id_i} + 12'd3;
  assign std_hit  = !item_i.is_extended
                  && (item_i.frame_id >= {18'd0, base_id_i})
                  && (item_i.frame_id <= {17'd0, base_top});
  assign std_diff = item_i.frame_id - {18'd0, base_id_i};

  assign for_me = item_i.is_extended && (dest == node_id_i);

  // table store window check
  assign is_store = for_me
                  && (msg_kind == cantrr_pkg::TypeCmd || msg_kind == cantrr_pkg::TypeRsp)
                  && (table_no == cantrr_pkg::StoreTable)
                  && (offset >= cantrr_pkg::StoreOffBase)
                  && (({1'b0, offset} + {7'd0, wr_len}) <= cantrr_pkg::StoreOffLimit);
  assign tbl_base = 9'(offset - cantrr_pkg::StoreOffBase);

  // per-lane byte enables, dropping bytes past the store end
  always_comb begin
    lane_en  = '0;
    lane_idx = '0;
    for (int i = 0; i < 8; i++) begin
      lane_idx   = {2'b00, tbl_base} + 11'(i);
      lane_en[i] = is_store && (4'(i) < wr_len) && (lane_idx < 11'(StoreBytes));
    end
  end

  // result assembly
  always_comb begin
    result_o = '0;
    if (std_hit) begin
      result_o.accepted = 1'b1;
    end else if (for_me) begin
      result_o.accepted = 1'b1;
      if (msg_kind == cantrr_pkg::TypeReq) begin
        result_o.send_response = 1'b1;
        result_o.response_id   = {1'b0, roff, cantrr_pkg::TypeRsp, node_id_i, src,
                                  b0[3:0], b0[4], 2'b00};
        result_o.response_len  = req_len;
        if (table_no == cantrr_pkg::StatusTable
            && offset == cantrr_pkg::StatusOffFault) begin
          result_o.response_payload = {item_i.fault_word,
                                       item_i.accel_x_hundredths,
                                       item_i.accel_y_hundredths,
                                       item_i.accel_z_hundredths};
        end else if (table_no == cantrr_pkg::StatusTable
                     && offset == cantrr_pkg::StatusOffSpeed) begin
          result_o.response_payload = {item_i.vehicle_speed, 48'd0};
        end
      end
    end
    result_o.bytes_stored = 4'($countones(lane_en));
  end

  // state update
  assign wr_o.grp_we   = std_hit;
  assign wr_o.grp_idx  = std_diff[1:0];
  assign wr_o.data     = item_i.frame_payload;
  assign wr_o.lane_en  = lane_en;
  assign wr_o.tbl_base = tbl_base;

endmodule

// File: sv/cantrr_store.sv
module cantrr_store #(
  parameter int StoreBytes = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_valid_i,
  input  cantrr_pkg::store_wr_t wr_i
);

  // table store split into even and odd 8-byte rows so an unaligned
  // 8-byte write touches each bank at one row
  localparam int BankRows = (StoreBytes + 15) / 16;
  localparam int RowAw    = (BankRows > 1) ? $clog2(BankRows) : 1;

  logic [63:0] grp_q [4];
  logic [63:0] even_mem [BankRows];
  logic [63:0] odd_mem  [BankRows];

  logic [9:0]  even_row, odd_row;
  logic [7:0]  even_be, odd_be;
  logic [63:0] even_data, odd_data;
  logic [9:0]  pos;

  // route payload lanes to bank byte positions
  always_comb begin
    even_row  = {5'd0, wr_i.tbl_base[8:4]} + {9'd0, wr_i.tbl_base[3]};
    odd_row   = {5'd0, wr_i.tbl_base[8:4]};
    even_be   = '0;
    odd_be    = '0;
    even_data = '0;
    odd_data  = '0;
    pos       = '0;
    for (int i = 0; i < 8; i++) begin
      pos = {1'b0, wr_i.tbl_base} + 10'(i);
      if (wr_valid_i && wr_i.lane_en[i]) begin
        if (pos[3]) begin
          odd_be[pos[2:0]]         = 1'b1;
          odd_data[pos[2:0]*8 +: 8] = wr_i.data[63-8*i -: 8];
        end else begin
          even_be[pos[2:0]]         = 1'b1;
          even_data[pos[2:0]*8 +: 8] = wr_i.data[63-8*i -: 8];
        end
      end
    end
  end

  // table store banks
  always_ff @(posedge clk_i) begin
    for (int p = 0; p < 8; p++) begin
      if (even_be[p]) begin
        even_mem[even_row[RowAw-1:0]][p*8 +: 8] <= even_data[p*8 +: 8];
      end
      if (odd_be[p]) begin
        odd_mem[odd_row[RowAw-1:0]][p*8 +: 8] <= odd_data[p*8 +: 8];
      end
    end
  end

  // engine data groups
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < 4; g++) begin
        grp_q[g] <= '0;
      end
    end else if (wr_valid_i && wr_i.grp_we) begin
      grp_q[wr_i.grp_idx] <= wr_i.data;
    end
  end

endmodule

// File: sv/can_table_request_responder.sv
// a request is held in the input register, decoded, and its result held in the result register
// throughput: one request per cycle unless the output stalls, set by the input and result registers
// the input register, when empty, still takes a request while a result waits under output stall
// reset clears both valid flags, the node id (5), the broadcast base (1512)
// and the engine data groups; the table store is not cleared
`include "can_table_request_responder_macros.svh"

module can_table_request_responder #(
  parameter int STORE_BYTES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               is_extended_i,
  input  logic [28:0]        frame_id_i,
  input  logic [3:0]         frame_len_i,
  input  logic [63:0]        frame_payload_i,
  input  logic [15:0]        fault_word_i,
  input  logic [15:0]        vehicle_speed_i,
  input  logic signed [15:0] accel_x_hundredths_i,
  input  logic signed [15:0] accel_y_hundredths_i,
  input  logic signed [15:0] accel_z_hundredths_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               accepted_o,
  output logic               send_response_o,
  output logic [28:0]        response_id_o,
  output logic [3:0]         response_len_o,
  output logic [63:0]        response_payload_o,
  output logic [3:0]         bytes_stored_o
);

  logic [3:0]            node_id;
  logic [10:0]           base_id;
  cantrr_pkg::item_t     in_item;
  cantrr_pkg::item_t     item_q, item_d;
  logic                  s1_valid_q, s1_valid_d;
  logic                  s2_valid_q, s2_valid_d;
  cantrr_pkg::result_t   res_q, res_d;
  cantrr_pkg::result_t   dec_res;
  cantrr_pkg::store_wr_t dec_wr;
  logic                  s1_stall;
  logic                  s1_fire;

  cantrr_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .node_id_o (node_id),
    .base_id_o (base_id)
  );

  // gather input fields
  assign in_item = '{
    is_extended:        is_extended_i,
    frame_id:           frame_id_i,
    frame_len:          frame_len_i,
    frame_payload:      frame_payload_i,
    fault_word:         fault_word_i,
    vehicle_speed:      vehicle_speed_i,
    accel_x_hundredths: accel_x_hundredths_i,
    accel_y_hundredths: accel_y_hundredths_i,
    accel_z_hundredths: accel_z_hundredths_i
  };

  // pipeline flow control
  assign s1_stall   = s2_valid_q && out_stall_i;
  assign in_stall_o = s1_valid_q && s1_stall;
  assign s1_fire    = s1_valid_q && !s1_stall;

  always_comb begin
    s1_valid_d = s1_valid_q;
    item_d     = item_q;
    if (!in_stall_o) begin
      s1_valid_d = in_valid_i;
      if (in_valid_i) begin
        item_d = in_item;
      end
    end
  end

  always_comb begin
    s2_valid_d = s2_valid_q;
    res_d      = res_q;
    if (!s1_stall) begin
      s2_valid_d = s1_valid_q;
      if (s1_valid_q) begin
        res_d = dec_res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
  end

  cantrr_decode #(
    .StoreBytes (STORE_BYTES)
  ) u_decode (
    .item_i    (item_q),
    .node_id_i (node_id),
    .base_id_i (base_id),
    .result_o  (dec_res),
    .wr_o      (dec_wr)
  );

  cantrr_store #(
    .StoreBytes (STORE_BYTES)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (s1_fire),
    .wr_i       (dec_wr)
  );

  // outputs
  assign out_valid_o        = s2_valid_q;
  assign accepted_o         = res_q.accepted;
  assign send_response_o    = res_q.send_response;
  assign response_id_o      = res_q.response_id;
  assign response_len_o     = res_q.response_len;
  assign response_payload_o = res_q.response_payload;
  assign bytes_stored_o     = res_q.bytes_stored;

  // checks
  `CANTRR_ASSERT(a_fire_fills_out, clk_i, rst_ni, s1_fire |=> out_valid_o)
  `CANTRR_ASSERT(a_stall_only_full, clk_i, rst_ni, in_stall_o |-> out_valid_o && out_stall_i)
  `CANTRR_ASSERT(a_resp_accepted, clk_i, rst_ni, out_valid_o && send_response_o |-> accepted_o)
  `CANTRR_ASSERT_NEVER(a_store_no_resp, clk_i, rst_ni,
                       out_valid_o && bytes_stored_o != 4'd0 && send_response_o)

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int StoreBytes  = 256;
  localparam int CycleLimit  = 400000;
  localparam int HoldCycles  = 64;
  localparam int PhaseFrames = 580;

  // message types without any effect and a table nobody serves
  localparam logic [2:0] TypeLowOther = 3'd3;
  localparam logic [2:0] TypeTopOther = 3'd7;
  localparam logic [4:0] PlainTable   = 5'd0;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               is_extended_i = 1'b0;
  logic [28:0]        frame_id_i = '0;
  logic [3:0]         frame_len_i = '0;
  logic [63:0]        frame_payload_i = '0;
  logic [15:0]        fault_word_i = '0;
  logic [15:0]        vehicle_speed_i = '0;
  logic signed [15:0] accel_x_hundredths_i = '0;
  logic signed [15:0] accel_y_hundredths_i = '0;
  logic signed [15:0] accel_z_hundredths_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               accepted_o;
  logic               send_response_o;
  logic [28:0]        response_id_o;
  logic [3:0]         response_len_o;
  logic [63:0]        response_payload_o;
  logic [3:0]         bytes_stored_o;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycle_cnt = 0;

  // clock, 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  can_table_request_responder #(
    .STORE_BYTES(StoreBytes)
  ) u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .is_extended_i       (is_extended_i),
    .frame_id_i          (frame_id_i),
    .frame_len_i         (frame_len_i),
    .frame_payload_i     (frame_payload_i),
    .fault_word_i        (fault_word_i),
    .vehicle_speed_i     (vehicle_speed_i),
    .accel_x_hundredths_i(accel_x_hundredths_i),
    .accel_y_hundredths_i(accel_y_hundredths_i),
    .accel_z_hundredths_i(accel_z_hundredths_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .accepted_o          (accepted_o),
    .send_response_o     (send_response_o),
    .response_id_o       (response_id_o),
    .response_len_o      (response_len_o),
    .response_payload_o  (response_payload_o),
    .bytes_stored_o      (bytes_stored_o)
  );

  // pack header fields into a 29-bit extended id, junk goes to bits 28, 1 and 0
  function automatic logic [28:0] ext_id(logic [4:0] tbl, logic [3:0] dst, logic [3:0] src,
                                         logic [2:0] typ, logic [9:0] off, logic [2:0] junk);
    return {junk[2], off, typ, src, dst, tbl[3:0], tbl[4], junk[1:0]};
  endfunction

  // predicts the response of every accepted request and checks results in order
  class response_tracker;
    logic [3:0]  node_id;
    logic [10:0] base_id;
    logic [63:0] engine_grp [4];
    logic [7:0]  store [StoreBytes];
    cantrr_pkg::result_t expected_responses [$];
    int          err_cnt;

    function new();
      node_id = cantrr_pkg::NodeIdReset;
      base_id = cantrr_pkg::BaseIdReset;
      foreach (engine_grp[i]) engine_grp[i] = '0;
      err_cnt = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] val);
      if (idx == cantrr_pkg::RegNodeId) begin
        node_id = val[3:0];
      end else begin
        base_id = val[10:0];
      end
    endfunction

    function cantrr_pkg::result_t predict_response(cantrr_pkg::item_t f);
      cantrr_pkg::result_t r;
      int unsigned id, n, idx, off;
      logic [4:0]  tbl;
      logic [3:0]  dst, src;
      logic [2:0]  typ;
      logic [7:0]  b0, b1, b2;
      r = '0;
      if (!f.is_extended) begin
        // engine data broadcast, exact compare without wrap
        id = 32'(f.frame_id);
        if (id >= base_id && id <= base_id + 3) begin
          engine_grp[id - base_id] = f.frame_payload;
          r.accepted = 1'b1;
        end
      end else begin
        tbl = {f.frame_id[2], f.frame_id[6:3]};
        dst = f.frame_id[10:7];
        src = f.frame_id[14:11];
        typ = f.frame_id[17:15];
        off = 32'(f.frame_id[27:18]);
        if (dst == node_id) begin
          r.accepted = 1'b1;
          if (typ == cantrr_pkg::TypeReq) begin
            // response header taken from the first three request bytes
            b0 = f.frame_payload[63:56];
            b1 = f.frame_payload[55:48];
            b2 = f.frame_payload[47:40];
            r.send_response = 1'b1;
            r.response_id = ext_id(b0[4:0], src, node_id, cantrr_pkg::TypeRsp,
                                   {b1[6:0], b2[7:5]}, 3'b000);
            r.response_len = (b2[3:0] > cantrr_pkg::MaxLen) ? cantrr_pkg::MaxLen : b2[3:0];
            if (tbl == cantrr_pkg::StatusTable && off == cantrr_pkg::StatusOffFault) begin
              r.response_payload = {f.fault_word, f.accel_x_hundredths,
                                    f.accel_y_hundredths, f.accel_z_hundredths};
            end else if (tbl == cantrr_pkg::StatusTable
                         && off == cantrr_pkg::StatusOffSpeed) begin
              r.response_payload = {f.vehicle_speed, 48'h0};
            end
          end else if (typ == cantrr_pkg::TypeCmd || typ == cantrr_pkg::TypeRsp) begin
            // table window write, length clamped to eight
            n = 32'((f.frame_len > cantrr_pkg::MaxLen) ? cantrr_pkg::MaxLen : f.frame_len);
            if (tbl == cantrr_pkg::StoreTable && off >= cantrr_pkg::StoreOffBase
                && off <= cantrr_pkg::StoreOffLimit - n) begin
              for (int i = 0; i < n; i++) begin
                idx = off - cantrr_pkg::StoreOffBase + i;
                if (idx < StoreBytes) begin
                  store[idx] = f.frame_payload[63 - 8 * i -: 8];
                  r.bytes_stored = r.bytes_stored + 4'd1;
                end
              end
            end
          end
        end
      end
      return r;
    endfunction

    function void note_frame(cantrr_pkg::item_t f);
      expected_responses.push_back(predict_response(f));
    endfunction

    function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t %s expected %h actual %h", $time, name, want, got);
        err_cnt++;
      end
    endfunction

    function void check_response(cantrr_pkg::result_t got);
      cantrr_pkg::result_t want;
      if (expected_responses.size() == 0) begin
        $display("%0t unexpected result expected none actual %h", $time, got);
        err_cnt++;
        return;
      end
      want = expected_responses.pop_front();
      cmp_field("accepted", 64'(want.accepted), 64'(got.accepted));
      cmp_field("send_response", 64'(want.send_response), 64'(got.send_response));
      cmp_field("response_id", 64'(want.response_id), 64'(got.response_id));
      cmp_field("response_len", 64'(want.response_len), 64'(got.response_len));
      cmp_field("response_payload", want.response_payload, got.response_payload);
      cmp_field("bytes_stored", 64'(want.bytes_stored), 64'(got.bytes_stored));
    endfunction
  endclass

  response_tracker tracker = new();

  // watch both handshakes
  always @(posedge clk_i) begin : monitor
    cantrr_pkg::item_t   seen_frame;
    cantrr_pkg::result_t seen_rsp;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        seen_frame = {is_extended_i, frame_id_i, frame_len_i, frame_payload_i, fault_word_i,
                      vehicle_speed_i, accel_x_hundredths_i, accel_y_hundredths_i,
                      accel_z_hundredths_i};
        tracker.note_frame(seen_frame);
      end
      if (out_valid_o && !out_stall_i) begin
        seen_rsp = {accepted_o, send_response_o, response_id_o, response_len_o,
                    response_payload_o, bytes_stored_o};
        tracker.check_response(seen_rsp);
      end
    end
  end

  // receiver stall, random or a long hold-off when one is asked for
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      out_stall_i <= 1'b1;
      hold_left <= HoldCycles;
      hold_served <= hold_served + 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // frame with random status words
  function automatic cantrr_pkg::item_t make_frame(logic ext, logic [28:0] id, logic [3:0] len,
                                                   logic [63:0] pay);
    cantrr_pkg::item_t f;
    f.is_extended = ext;
    f.frame_id = id;
    f.frame_len = len;
    f.frame_payload = pay;
    f.fault_word = 16'($urandom);
    f.vehicle_speed = 16'($urandom);
    f.accel_x_hundredths = 16'($urandom);
    f.accel_y_hundredths = 16'($urandom);
    f.accel_z_hundredths = 16'($urandom);
    return f;
  endfunction

  // mostly well-formed frames for this node, the rest noise
  function automatic cantrr_pkg::item_t random_frame();
    cantrr_pkg::item_t f;
    int unsigned pick, v;
    logic [4:0]  tbl;
    logic [2:0]  typ;
    logic [9:0]  off;
    f = make_frame(1'b0, 29'($urandom), 4'($urandom_range(8)), {$urandom, $urandom});
    if ($urandom_range(99) < 15) f.frame_len = 4'($urandom);
    pick = $urandom_range(99);
    if (pick < 15) begin
      v = tracker.base_id + $urandom_range(5);
      f.frame_id = (v == 0) ? '0 : 29'(v - 1);
    end else if (pick < 20) begin
      f.frame_id = 29'($urandom_range(2047));
    end else if (pick < 23) begin
      f.is_extended = 1'b0;
    end else if (pick < 80) begin
      f.is_extended = 1'b1;
      tbl = 5'($urandom);
      off = 10'($urandom);
      pick = $urandom_range(99);
      if (pick < 35) begin
        typ = cantrr_pkg::TypeReq;
        if ($urandom_range(1)) begin
          tbl = cantrr_pkg::StatusTable;
          off = $urandom_range(1) ? cantrr_pkg::StatusOffFault : cantrr_pkg::StatusOffSpeed;
        end
      end else if (pick < 80) begin
        typ = $urandom_range(1) ? cantrr_pkg::TypeCmd : cantrr_pkg::TypeRsp;
        if ($urandom_range(4) != 0) begin
          tbl = cantrr_pkg::StoreTable;
          off = 10'($urandom_range(520, 244));
        end
      end else begin
        typ = 3'($urandom_range(7, 3));
      end
      f.frame_id = ext_id(tbl, tracker.node_id, 4'($urandom), typ, off, 3'($urandom));
    end else begin
      f.is_extended = 1'b1;
    end
    return f;
  endfunction

  // offer one request and hold it until taken
  task automatic send_frame(input cantrr_pkg::item_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    is_extended_i <= f.is_extended;
    frame_id_i <= f.frame_id;
    frame_len_i <= f.frame_len;
    frame_payload_i <= f.frame_payload;
    fault_word_i <= f.fault_word;
    vehicle_speed_i <= f.vehicle_speed;
    accel_x_hundredths_i <= f.accel_x_hundredths;
    accel_y_hundredths_i <= f.accel_y_hundredths;
    accel_z_hundredths_i <= f.accel_z_hundredths;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // register write followed by a read back
  task automatic program_reg(input logic idx, input logic [31:0] val);
    logic [2:0] addr;
    addr = {idx, 2'b00};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== val) begin
      $display("%0t register %0d expected %h actual %h", $time, addr, val, prdata);
      tracker.err_cnt++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    tracker.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  // wait for every outstanding response, then let the pipeline settle
  task automatic drain_responses();
    while (tracker.expected_responses.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // run time limit
  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("can_table_request_responder: mismatch");
    $finish;
  end

  initial begin : stimulus
    cantrr_pkg::item_t f;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames under the reset configuration
    send_frame(make_frame(1'b0, 29'd1512, 4'd8, '1));
    send_frame(make_frame(1'b0, 29'd1513, 4'd0, 64'h0123_4567_89ab_cdef));
    send_frame(make_frame(1'b0, 29'd1515, 4'd15, '0));
    send_frame(make_frame(1'b0, 29'd1516, 4'd8, '1));
    send_frame(make_frame(1'b0, 29'd1511, 4'd8, '1));
    // standard id with high bits set never matches
    send_frame(make_frame(1'b0, 29'h1000_05e8, 4'd8, '1));
    send_frame(make_frame(1'b0, '0, 4'd0, '0));
    // status requests with extreme words
    f = make_frame(1'b1, ext_id(cantrr_pkg::StatusTable, cantrr_pkg::NodeIdReset, 4'd3,
                                cantrr_pkg::TypeReq, cantrr_pkg::StatusOffFault, 3'b000),
                   4'd3, 64'h1f_ff_2f_00_0000_0000);
    f.fault_word = 16'hffff;
    f.accel_x_hundredths = 16'sh8000;
    f.accel_y_hundredths = 16'sh7fff;
    f.accel_z_hundredths = 16'sh0000;
    send_frame(f);
    f = make_frame(1'b1, ext_id(cantrr_pkg::StatusTable, cantrr_pkg::NodeIdReset, 4'd15,
                                cantrr_pkg::TypeReq, cantrr_pkg::StatusOffFault, 3'b111),
                   4'd15, '1);
    f.fault_word = 16'h0000;
    f.accel_x_hundredths = 16'sh7fff;
    f.accel_y_hundredths = 16'sh8000;
    f.accel_z_hundredths = 16'shffff;
    send_frame(f);
    f = make_frame(1'b1, ext_id(cantrr_pkg::StatusTable, cantrr_pkg::NodeIdReset, 4'd0,
                                cantrr_pkg::TypeReq, cantrr_pkg::StatusOffSpeed, 3'b101),
                   4'd8, {$urandom, $urandom});
    f.vehicle_speed = 16'hffff;
    send_frame(f);
    // table with bit four set is not the status table
    send_frame(make_frame(1'b1, ext_id({1'b1, cantrr_pkg::StatusTable[3:0]},
                                       cantrr_pkg::NodeIdReset, 4'd1, cantrr_pkg::TypeReq,
                                       cantrr_pkg::StatusOffFault, 3'b000), 4'd8, '1));
    send_frame(make_frame(1'b1, ext_id(PlainTable, cantrr_pkg::NodeIdReset, 4'd15,
                                       cantrr_pkg::TypeReq, 10'd0, 3'b010), 4'd0, '0));
    // table window writes at and around the bounds
    send_frame(make_frame(1'b1, ext_id(cantrr_pkg::StoreTable, cantrr_pkg::NodeIdReset, 4'd2,
                                       cantrr_pkg::TypeCmd, 10'd256, 3'b000),
                          4'd8, {$urandom, $urandom}));
    send_frame(make_frame(1'b1, ext_id(cantrr_pkg::StoreTable, cantrr_pkg::NodeIdReset, 4'd2,
                                       cantrr_pkg::TypeRsp, 10'd504, 3'b000),
                          4'd8, {$urandom, $urandom}));
    send_frame(make_frame(1'b1, ext_id(cantrr_pkg::StoreTable, cantrr_pkg::NodeIdReset, 4'd2,
                                       cantrr_pkg::TypeCmd, 10'd505, 3'b000),
                          4'd8, {$urandom, $urandom}));
    // length above eight acts as eight
    send_frame(make_frame(1'b1, ext_id(cantrr_pkg::StoreTable, cantrr_pkg::NodeIdReset, 4'd2,
                                       cantrr_pkg::TypeCmd, 10'd300, 3'b000),
                          4'd12, {$urandom, $urandom}));
    send_frame(make_frame(1'b1, ext_id(cantrr_pkg::StoreTable, cantrr_pkg::NodeIdReset, 4'd2,
                                       cantrr_pkg::TypeCmd, 10'd512, 3'b000),
                          4'd0, {$urandom, $urandom}));
    send_frame(make_frame(1'b1, ext_id(cantrr_pkg::StoreTable, cantrr_pkg::NodeIdReset, 4'd2,
                                       cantrr_pkg::TypeRsp, 10'd255, 3'b000),
                          4'd1, {$urandom, $urandom}));
    send_frame(make_frame(1'b1, ext_id(cantrr_pkg::StoreTable, cantrr_pkg::NodeIdReset, 4'd2,
                                       cantrr_pkg::TypeRsp, 10'd511, 3'b000),
                          4'd1, {$urandom, $urandom}));
    send_frame(make_frame(1'b1, ext_id(cantrr_pkg::StoreTable, cantrr_pkg::NodeIdReset, 4'd2,
                                       cantrr_pkg::TypeCmd, 10'd1023, 3'b111),
                          4'd8, {$urandom, $urandom}));
    // other message types are accepted and do nothing else
    send_frame(make_frame(1'b1, ext_id(cantrr_pkg::StoreTable, cantrr_pkg::NodeIdReset, 4'd4,
                                       TypeLowOther, 10'd256, 3'b000), 4'd8, '1));
    send_frame(make_frame(1'b1, ext_id(cantrr_pkg::StatusTable, cantrr_pkg::NodeIdReset,
                                       4'd4, TypeTopOther, cantrr_pkg::StatusOffFault,
                                       3'b000), 4'd8, '1));
    // not for this node, or a write to a table other than the window
    send_frame(make_frame(1'b1, ext_id(cantrr_pkg::StatusTable, 4'd4, 4'd4,
                                       cantrr_pkg::TypeReq, cantrr_pkg::StatusOffFault,
                                       3'b000), 4'd8, '1));
    send_frame(make_frame(1'b1, ext_id({1'b1, cantrr_pkg::StoreTable[3:0]},
                                       cantrr_pkg::NodeIdReset, 4'd2, cantrr_pkg::TypeCmd,
                                       10'd256, 3'b000), 4'd8, '1));
    send_frame(make_frame(1'b1, '1, 4'd15, '1));
    send_frame(make_frame(1'b1, '0, 4'd0, '0));
    in_valid_i <= 1'b0;
    drain_responses();

    // random phases, each with its own configuration and idle pattern
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct = 24;
          recv_idle_pct <= 71;
          program_reg(cantrr_pkg::RegNodeId, 32'd0);
          program_reg(cantrr_pkg::RegBaseId, 32'd0);
        end
        1: begin
          send_idle_pct = 71;
          recv_idle_pct <= 24;
          program_reg(cantrr_pkg::RegNodeId, 32'd15);
          program_reg(cantrr_pkg::RegBaseId, 32'd2044);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
          program_reg(cantrr_pkg::RegNodeId, 32'($urandom_range(15)));
          program_reg(cantrr_pkg::RegBaseId, 32'($urandom_range(2044)));
        end
      endcase
      // long receiver hold-off while requests keep coming
      hold_asked <= hold_asked + 1;
      repeat (PhaseFrames) send_frame(random_frame());
      in_valid_i <= 1'b0;
      drain_responses();
    end

    if (tracker.err_cnt == 0) begin
      $display("can_table_request_responder: match");
    end else begin
      $display("can_table_request_responder: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/cantrr_pkg.sv
sv/cantrr_cfg.sv
sv/cantrr_decode.sv
sv/cantrr_store.sv
sv/can_table_request_responder.sv
tb/sv/tb_top.sv
